>>> rtl/core/npat_pkg.sv
// ----------------------------------------------------------------------------
// npat_pkg: shared constants and types for the node presence aging table
// Table geometry, field widths, request codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package npat_pkg;

  localparam int NODE_COUNT = 255;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int ID_W       = 8;
  localparam int TIME_W     = 32;

  localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd10000;
  localparam logic [ID_W-1:0]   NO_NODE      = 8'd255;

  typedef enum logic [1:0] {
    REQ_REFRESH = 2'd0,
    REQ_SWEEP   = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_CTRL    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CTRL,
    ST_FIND,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/npat_stamp_ram.sv
// ----------------------------------------------------------------------------
// npat_stamp_ram: last-seen stamp store
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
`default_nettype none

module npat_stamp_ram
  import npat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [TIME_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]  raddr,
  output logic      [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/npat_age_unit.sv
// ----------------------------------------------------------------------------
// npat_age_unit: shared age compare
// Flags a stamp whose modular age against now exceeds the expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module npat_age_unit
  import npat_pkg::*;
(
  input  wire logic [TIME_W-1:0] now,
  input  wire logic [TIME_W-1:0] stamp,
  input  wire logic [TIME_W-1:0] expiry,
  output logic                   expired
);

  logic [TIME_W-1:0] age;

  // age wraps modulo 2^TIME_W
  assign age     = now - stamp;
  assign expired = (age > expiry);

endmodule

`default_nettype wire

>>> rtl/core/node_presence_aging_table.sv
// ----------------------------------------------------------------------------
// node_presence_aging_table: presence table of network nodes with aging
// Refresh, expiry sweep, next-active query and controller refresh requests,
// one result word per request, run by a small sequencer around one shared
// age compare unit and a stamp memory.
// ----------------------------------------------------------------------------
// Sequence: a refresh or query runs a wraparound scan to the next active
//   node (ST_FIND, 1 to 255 entries), then raises the result strobe in
//   ST_DONE. A controller refresh passes ST_CTRL first, an expiry sweep
//   ST_SWEEP (one stamp read per entry plus the read pipeline stage).
// Requests: one at a time; busy drops as the strobe ends, and a start
//   while busy is ignored.
// Reset: synchronous, active low; clears valid marks, count, controller and
//   loads the expiry default. Stamps are not cleared. The result strobe lasts
//   one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module node_presence_aging_table
  import npat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request word
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [ID_W-1:0]   in_node_id,
  input  wire logic [TIME_W-1:0] in_now,
  // expiry register
  input  wire logic              cfg_wr_en,
  input  wire logic [TIME_W-1:0] cfg_wr_data,
  // result word
  output logic                   out_valid,
  output logic [7:0]             out_active_count,
  output logic [7:0]             out_next_active,
  output logic [7:0]             out_controller_id,
  output logic                   out_was_active
);

  // First entry of the wraparound scan: the one after id, or entry 0 when
  // id is the last entry or lies beyond the table.
  function automatic logic [IDX_W-1:0] scan_first(input logic [ID_W-1:0] id);
    if (id >= ID_W'(NODE_COUNT - 1)) begin
      scan_first = '0;
    end else begin
      scan_first = IDX_W'(id) + 1'b1;
    end
  endfunction

  // Entries to visit: the whole table for an out-of-range id, else all but id.
  function automatic logic [CNT_W-1:0] scan_len(input logic [ID_W-1:0] id);
    if (id >= ID_W'(NODE_COUNT)) begin
      scan_len = CNT_W'(NODE_COUNT);
    end else begin
      scan_len = CNT_W'(NODE_COUNT - 1);
    end
  endfunction

  state_t              state_r,      state_nxt;
  logic [ID_W-1:0]     id_r,         id_nxt;
  logic [TIME_W-1:0]   now_r,        now_nxt;
  logic                was_r,        was_nxt;
  logic [ID_W-1:0]     next_r,       next_nxt;
  logic [ID_W-1:0]     ctrl_node_r,  ctrl_node_nxt;
  logic [TIME_W-1:0]   ctrl_stamp_r, ctrl_stamp_nxt;
  logic [TIME_W-1:0]   expiry_r;
  logic [NODE_COUNT-1:0] valid_r,    valid_nxt;
  logic [CNT_W-1:0]    count_r,      count_nxt;
  logic [CNT_W-1:0]    idx_r,        idx_nxt;
  logic                chk_vld_r,    chk_vld_nxt;
  logic [IDX_W-1:0]    chk_idx_r,    chk_idx_nxt;
  logic [IDX_W-1:0]    pos_r,        pos_nxt;
  logic [CNT_W-1:0]    left_r,       left_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  logic [TIME_W-1:0]   ram_rdata;
  logic [TIME_W-1:0]   age_stamp;
  logic                age_expired;

  logic                in_range;
  logic [IDX_W-1:0]    in_idx;
  logic                in_was;

  // ------------------------------------------------------------------------
  // Stamp store and shared age compare
  // ------------------------------------------------------------------------
  npat_stamp_ram u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_now),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The compare unit serves the controller check in ST_CTRL and every
  // entry check of a sweep otherwise.
  assign age_stamp = (state_r == ST_CTRL) ? ctrl_stamp_r : ram_rdata;

  npat_age_unit u_age_unit (
    .now     (now_r),
    .stamp   (age_stamp),
    .expiry  (expiry_r),
    .expired (age_expired)
  );

  // ------------------------------------------------------------------------
  // Request decode at accept
  // ------------------------------------------------------------------------
  assign in_range  = (in_node_id < ID_W'(NODE_COUNT));
  assign in_idx    = in_range ? IDX_W'(in_node_id) : '0;
  assign in_was    = in_range && valid_r[in_idx];
  assign ram_waddr = in_idx;
  assign ram_raddr = idx_r[IDX_W-1:0];

  // ------------------------------------------------------------------------
  // Sequencer: next state and datapath updates
  // ------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    id_nxt         = id_r;
    now_nxt        = now_r;
    was_nxt        = was_r;
    next_nxt       = next_r;
    ctrl_node_nxt  = ctrl_node_r;
    ctrl_stamp_nxt = ctrl_stamp_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    pos_nxt        = pos_r;
    left_nxt       = left_r;
    ram_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          id_nxt  = in_node_id;
          now_nxt = in_now;
          was_nxt = in_was;
          pos_nxt  = scan_first(in_node_id);
          left_nxt = scan_len(in_node_id);
          case (req_t'(in_req_type))
            REQ_REFRESH: begin
              // stamp and mark the node; ids beyond the table are ignored
              if (in_range) begin
                ram_we            = 1'b1;
                valid_nxt[in_idx] = 1'b1;
                if (!valid_r[in_idx]) begin
                  count_nxt = count_r + 1'b1;
                end
              end
              state_nxt = ST_FIND;
            end
            REQ_SWEEP: begin
              idx_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            REQ_QUERY: begin
              state_nxt = ST_FIND;
            end
            REQ_CTRL: begin
              state_nxt = ST_CTRL;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SWEEP: begin
        // check the entry whose stamp was read last cycle; drop it if aged out
        if (chk_vld_r && valid_r[chk_idx_r] && age_expired) begin
          valid_nxt[chk_idx_r] = 1'b0;
          count_nxt            = count_r - 1'b1;
        end
        if (idx_r < CNT_W'(NODE_COUNT)) begin
          // issue the next stamp read
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else begin
          state_nxt = ST_FIND;
        end
      end

      ST_CTRL: begin
        // same node: restamp; other node: take over only after silence
        if (ctrl_node_r != id_r) begin
          if (age_expired) begin
            ctrl_node_nxt  = id_r;
            ctrl_stamp_nxt = now_r;
          end
        end else begin
          ctrl_stamp_nxt = now_r;
        end
        state_nxt = ST_FIND;
      end

      ST_FIND: begin
        // advance one entry per cycle until an active node turns up or the scan ends
        if (valid_r[pos_r]) begin
          next_nxt  = ID_W'(pos_r);
          state_nxt = ST_DONE;
        end else if (left_r == CNT_W'(1)) begin
          next_nxt  = NO_NODE;
          state_nxt = ST_DONE;
        end else begin
          pos_nxt  = (pos_r == IDX_W'(NODE_COUNT - 1)) ? '0 : pos_r + 1'b1;
          left_nxt = left_r - 1'b1;
        end
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      ctrl_node_r  <= '0;
      ctrl_stamp_r <= '0;
      chk_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      ctrl_node_r  <= ctrl_node_nxt;
      ctrl_stamp_r <= ctrl_stamp_nxt;
      chk_vld_r    <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RESET;
    end else if (cfg_wr_en) begin
      expiry_r <= cfg_wr_data;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    now_r     <= now_nxt;
    was_r     <= was_nxt;
    next_r    <= next_nxt;
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    left_r    <= left_nxt;
  end

  // ------------------------------------------------------------------------
  // Ports
  // ------------------------------------------------------------------------
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = (state_r == ST_DONE);
  assign out_active_count  = 8'(count_r);
  assign out_next_active   = next_r;
  assign out_controller_id = ctrl_node_r;
  assign out_was_active    = was_r;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("active count out of step with valid marks");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_next_is_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_active == NO_NODE) ||
                  valid_r[out_next_active[IDX_W-1:0]])
    else $error("reported next node is not active");

endmodule

`default_nettype wire
